[hw/rtl/rste_pkg.sv]
// Shared constants, opcodes and controller/datapath interface types for the range sum tree.
package rste_pkg;

  localparam int LEAVES  = 1024;
  localparam int DEPTH   = 2 * LEAVES;
  localparam int LEAF_W  = $clog2(LEAVES);
  localparam int NODE_W  = LEAF_W + 1;
  localparam int BOUND_W = NODE_W + 1;

  localparam int OPCODE_W = 2;
  localparam int INDEX_W  = 10;
  localparam int RIGHT_W  = 11;
  localparam int VALUE_W  = 32;
  localparam int SUM_W    = 64;

  localparam logic [OPCODE_W-1:0] OP_SET   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the accepted request
    logic leaf_rd;   // read the leaf word
    logic leaf_wr;   // write the new leaf word
    logic sib_rd;    // read the sibling of the current node
    logic sib_wr;    // write the parent sum and climb one level
    logic q_lo_rd;   // read the node at the left bound
    logic q_lo_acc;  // fold it into the left sum, step the left bound
    logic q_hi_rd;   // step the right bound down and read that node
    logic q_hi_acc;  // fold it into the right sum
    logic q_shift;   // move both bounds up one level
    logic res_load;  // load the output register
    logic clr_wr;    // clear one word of the node store
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic                pos_ok;
    logic                parent_is_root;
    logic                lo_lt_hi;
    logic                lo_odd;
    logic                hi_odd;
    logic                clr_last;
  } sts_t;

endpackage

[hw/rtl/rste_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module rste_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/rste_ctrl.sv]
// Sequencer for clearing, point update and range query.
module rste_ctrl
  import rste_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_U_RD,
    S_U_LEAF,
    S_U_SRD,
    S_U_SWR,
    S_Q_L,
    S_Q_LW,
    S_Q_R,
    S_Q_RW,
    S_Q_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if ((sts.op == OP_SET || sts.op == OP_ADD) && sts.pos_ok) begin
          state_next = S_U_RD;
        end else if (sts.op == OP_QUERY) begin
          state_next = S_Q_L;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_U_RD: begin
        cmd.leaf_rd = 1'b1;
        state_next  = S_U_LEAF;
      end
      S_U_LEAF: begin
        cmd.leaf_wr = 1'b1;
        state_next  = S_U_SRD;
      end
      S_U_SRD: begin
        cmd.sib_rd = 1'b1;
        state_next = S_U_SWR;
      end
      S_U_SWR: begin
        cmd.sib_wr = 1'b1;
        state_next = sts.parent_is_root ? S_IDLE : S_U_SRD;
      end
      S_Q_L: begin
        if (!sts.lo_lt_hi) begin
          state_next = S_Q_DONE;
        end else if (sts.lo_odd) begin
          cmd.q_lo_rd = 1'b1;
          state_next  = S_Q_LW;
        end else begin
          state_next = S_Q_R;
        end
      end
      S_Q_LW: begin
        cmd.q_lo_acc = 1'b1;
        state_next   = S_Q_R;
      end
      S_Q_R: begin
        if (sts.hi_odd) begin
          cmd.q_hi_rd = 1'b1;
          state_next  = S_Q_RW;
        end else begin
          cmd.q_shift = 1'b1;
          state_next  = S_Q_L;
        end
      end
      S_Q_RW: begin
        cmd.q_hi_acc = 1'b1;
        cmd.q_shift  = 1'b1;
        state_next   = S_Q_L;
      end
      S_Q_DONE: begin
        // Hold until the output register is free.
        if (!out_valid || out_ready) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/rste_dp.sv]
// Datapath: node store, tree walk registers, adders and the result register.
module rste_dp
  import rste_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  cmd_t                       cmd,
  output sts_t                       sts,
  input  logic [OPCODE_W-1:0]        opcode,
  input  logic [INDEX_W-1:0]         index,
  input  logic [RIGHT_W-1:0]         right_end,
  input  logic signed [VALUE_W-1:0]  value,
  output logic signed [SUM_W-1:0]    range_sum
);

  localparam logic [BOUND_W-1:0] LEAVES_B = BOUND_W'(LEAVES);
  localparam logic [NODE_W-1:0]  LEAVES_N = NODE_W'(LEAVES);
  localparam logic [NODE_W-1:0]  LAST_N   = NODE_W'(DEPTH - 1);

  logic [OPCODE_W-1:0] op_q;
  logic                pos_ok;
  logic [SUM_W-1:0]    val_q;
  logic [NODE_W-1:0]   node;
  logic [SUM_W-1:0]    acc;
  logic [BOUND_W-1:0]  lo;
  logic [BOUND_W-1:0]  hi;
  logic [SUM_W-1:0]    left_acc;
  logic [SUM_W-1:0]    right_acc;
  logic [NODE_W-1:0]   clr_addr;

  logic                we;
  logic [NODE_W-1:0]   waddr;
  logic [SUM_W-1:0]    wdata;
  logic [NODE_W-1:0]   raddr;
  logic [SUM_W-1:0]    rdata;

  logic [BOUND_W-1:0]  idx_ext;
  logic [BOUND_W-1:0]  right_ext;
  logic [BOUND_W-1:0]  hi_dec;

  assign idx_ext   = BOUND_W'(index);
  assign right_ext = BOUND_W'(right_end);
  assign hi_dec    = hi - BOUND_W'(1);

  rste_ram #(
    .WIDTH (SUM_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Write port: clearing pass, leaf write or parent write.
  always_comb begin
    we    = cmd.clr_wr | cmd.leaf_wr | cmd.sib_wr;
    waddr = clr_addr;
    wdata = '0;
    if (cmd.leaf_wr) begin
      waddr = node;
      wdata = (op_q == OP_SET) ? val_q : rdata + val_q;
    end else if (cmd.sib_wr) begin
      waddr = node >> 1;
      wdata = acc + rdata;
    end
  end

  // Read port.
  always_comb begin
    raddr = node;
    if (cmd.sib_rd) begin
      raddr = node ^ NODE_W'(1);
    end else if (cmd.q_lo_rd) begin
      raddr = lo[NODE_W-1:0];
    end else if (cmd.q_hi_rd) begin
      raddr = hi_dec[NODE_W-1:0];
    end else if (cmd.leaf_rd) begin
      raddr = node;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr <= clr_addr + NODE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q      <= opcode;
      pos_ok    <= (idx_ext < LEAVES_B);
      val_q     <= {{(SUM_W - VALUE_W){value[VALUE_W-1]}}, value};
      node      <= LEAVES_N + NODE_W'(index);
      lo        <= LEAVES_B + ((idx_ext > LEAVES_B) ? LEAVES_B : idx_ext);
      hi        <= LEAVES_B + ((right_ext > LEAVES_B) ? LEAVES_B : right_ext);
      left_acc  <= '0;
      right_acc <= '0;
    end
    if (cmd.leaf_wr) begin
      acc <= wdata;
    end
    if (cmd.sib_wr) begin
      acc  <= wdata;
      node <= node >> 1;
    end
    if (cmd.q_lo_acc) begin
      left_acc <= left_acc + rdata;
      lo       <= lo + BOUND_W'(1);
    end
    if (cmd.q_hi_rd) begin
      hi <= hi_dec;
    end
    if (cmd.q_hi_acc) begin
      right_acc <= rdata + right_acc;
    end
    if (cmd.q_shift) begin
      lo <= lo >> 1;
      hi <= hi >> 1;
    end
    if (cmd.res_load) begin
      range_sum <= left_acc + right_acc;
    end
  end

  assign sts.op             = op_q;
  assign sts.pos_ok         = pos_ok;
  assign sts.parent_is_root = ((node >> 1) == NODE_W'(1));
  assign sts.lo_lt_hi       = (lo < hi);
  assign sts.lo_odd         = lo[0];
  assign sts.hi_odd         = hi[0];
  assign sts.clr_last       = (clr_addr == LAST_N);

endmodule

[hw/rtl/range_sum_tree_engine.sv]
// Top level: segment tree engine with point set/add and half-open range sum query.
// Set and add: accept, dispatch, leaf read, leaf write, then one sibling read and one parent
// write per level for the 10 levels above the leaves. A query: accept, dispatch, then per
// level walked (at most 11) a left and a right bound step, each with an optional read and
// fold, and a shift; a final bound check, and the result load, which holds while the output
// register is full. One request in flight; rst clears all 2048 store words before in_ready.
module range_sum_tree_engine
  import rste_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [OPCODE_W-1:0]        opcode,
  input  logic [INDEX_W-1:0]         index,
  input  logic [RIGHT_W-1:0]         right_end,
  input  logic signed [VALUE_W-1:0]  value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SUM_W-1:0]    range_sum
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer: clearing pass, update walk to the root, query walk over both bounds.
  rste_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Node store with one read and one write per cycle, plus the walk registers.
  rste_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .opcode    (opcode),
    .index     (index),
    .right_end (right_end),
    .value     (value),
    .range_sum (range_sum)
  );

endmodule

[hw/rtl/rste_checker.sv]
// Port-level checks for the range sum tree engine, bound to the top level.
module rste_checker
  import rste_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SUM_W-1:0]    range_sum
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(range_sum))
    else $error("result changed while stalled");

  // Reset drops any pending result.
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Clearing pass keeps the input closed after reset.
  a_rst_busy: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input open during clearing pass");

  // One request at a time: busy right after an accept.
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  // A result appears only at the end of a request being worked on.
  a_res_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a request in flight");

endmodule

bind range_sum_tree_engine rste_checker u_rste_checker (.*);

[tb/testbench.sv]
// Self-checking bench for the range sum tree: mixed traffic checked against a leaf array.
`timescale 1ns / 1ps

module testbench;
  import rste_pkg::*;

  // Opcode 3 has no meaning in the block; it must be swallowed without a result.
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_REQS  = 1430;
  localparam int IDLE_LIMIT   = 20000;  // covers the clearing pass over all 2048 words many times over
  localparam int DRAIN_CYCLES = 60;     // lets a set or add still in flight finish

  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic [INDEX_W-1:0]  idx;
    logic [RIGHT_W-1:0]  rend;
    logic [VALUE_W-1:0]  val;
  } tree_req_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [OPCODE_W-1:0]       opcode = '0;
  logic [INDEX_W-1:0]        index = '0;
  logic [RIGHT_W-1:0]        right_end = '0;
  logic signed [VALUE_W-1:0] value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [SUM_W-1:0]   range_sum;

  range_sum_tree_engine dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .index     (index),
    .right_end (right_end),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .range_sum (range_sum)
  );

  // Requests not yet taken by the block, oldest first.
  tree_req_t pending_reqs[$];
  // Sums owed by queries already taken, oldest first.
  logic [SUM_W-1:0] expected_sums[$];
  // Mirror of the leaf words; inner tree nodes are never needed since a range
  // sum over leaves wraps the same way the tree does.
  logic [SUM_W-1:0] leaf_vals [0:LEAVES-1];

  logic             req_taken = 1'b0;
  logic [SUM_W-1:0] want_sum;
  int               fail_count = 0;
  int               idle_cycles = 0;
  int               burst_left = 0;
  int               gap_left = 0;
  int               stall_mode = 0;
  int               mode_left = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // Hold reset from the start, release it on a falling edge.
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  initial begin
    for (int p = 0; p < LEAVES; p++) leaf_vals[LEAF_W'(p)] = '0;
  end

  // Apply one accepted request to the leaf mirror; a query owes one sum.
  function automatic void apply_request(tree_req_t r);
    logic [SUM_W-1:0] acc;
    int               hi;
    case (r.op)
      OP_SET: leaf_vals[r.idx] = {{(SUM_W-VALUE_W){r.val[VALUE_W-1]}}, r.val};
      OP_ADD: leaf_vals[r.idx] = leaf_vals[r.idx] + {{(SUM_W-VALUE_W){r.val[VALUE_W-1]}}, r.val};
      OP_QUERY: begin
        // Clamp the right bound to the leaf count; left >= right sums nothing.
        hi  = (r.rend > LEAVES) ? LEAVES : int'(r.rend);
        acc = '0;
        for (int p = int'(r.idx); p < hi; p++) acc += leaf_vals[LEAF_W'(p)];
        expected_sums.push_back(acc);
      end
      default: ;  // drop: unused opcode leaves the tree alone
    endcase
  endfunction

  function automatic void queue_req(logic [OPCODE_W-1:0] op, logic [INDEX_W-1:0] idx,
                                    logic [RIGHT_W-1:0] rend, logic [VALUE_W-1:0] val);
    tree_req_t r;
    r.op   = op;
    r.idx  = idx;
    r.rend = rend;
    r.val  = val;
    pending_reqs.push_back(r);
  endfunction

  // Favor the two ends of the array so leaves get hit repeatedly and grow past 32 bits.
  function automatic logic [INDEX_W-1:0] pick_index();
    case ($urandom_range(0, 9))
      0, 1:    return INDEX_W'($urandom_range(0, 15));
      2:       return INDEX_W'($urandom_range(LEAVES - 16, LEAVES - 1));
      default: return INDEX_W'($urandom_range(0, LEAVES - 1));
    endcase
  endfunction

  // Sender: present pending requests in bursts of random length with random gaps.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !req_taken) begin
        // hold the request until the block takes it
      end else begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 16);
          case ($urandom_range(0, 7))
            0, 1:    gap_left = 0;
            2:       gap_left = $urandom_range(20, 60);
            default: gap_left = $urandom_range(1, 8);
          endcase
        end
        if (burst_left != 0 && pending_reqs.size() != 0) begin
          in_valid  <= 1'b1;
          opcode    <= pending_reqs[0].op;
          index     <= pending_reqs[0].idx;
          right_end <= pending_reqs[0].rend;
          value     <= pending_reqs[0].val;
          burst_left--;
        end else begin
          in_valid <= 1'b0;
          if (gap_left != 0) gap_left--;
        end
      end
    end
  end

  // Receiver: switch between always ready, coin-flip ready and heavy stalling.
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(16, 300);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Take requests into the predictor, check results, and watch for a hang.
  always @(posedge clk) begin
    req_taken <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready) apply_request(pending_reqs.pop_front());
      if (out_valid && out_ready) begin
        if (expected_sums.size() == 0) begin
          $display("%0t: range_sum with no query pending: expected none, actual %0d",
                   $time, range_sum);
          fail_count++;
        end else begin
          want_sum = expected_sums.pop_front();
          if (range_sum !== want_sum) begin
            $display("%0t: range_sum mismatch: expected %0d, actual %0d",
                     $time, $signed(want_sum), range_sum);
            fail_count++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("FAIL range_sum_tree_engine");
        $finish;
      end
    end
  end

  initial begin
    int                  sel;
    logic [INDEX_W-1:0]  idx;
    logic [RIGHT_W-1:0]  rend;
    logic [VALUE_W-1:0]  v;

    // Directed: fresh tree, value extremes at both ends, bound clamping,
    // empty and inverted ranges, the unused opcode, odd-aligned ranges.
    queue_req(OP_QUERY, '0, RIGHT_W'(LEAVES), '0);
    queue_req(OP_SET, '0, '0, 32'h7FFF_FFFF);
    queue_req(OP_SET, INDEX_W'(LEAVES - 1), '0, 32'h8000_0000);
    queue_req(OP_ADD, INDEX_W'(LEAVES - 1), '0, 32'hFFFF_FFFF);
    queue_req(OP_ADD, '0, '0, 32'h7FFF_FFFF);
    queue_req(OP_SET, INDEX_W'(512), '0, 32'd12345);
    queue_req(OP_QUERY, '0, RIGHT_W'(LEAVES), '0);
    queue_req(OP_QUERY, '0, 11'h7FF, '0);
    queue_req(OP_QUERY, INDEX_W'(LEAVES - 1), RIGHT_W'(LEAVES), '0);
    queue_req(OP_QUERY, INDEX_W'(LEAVES - 1), 11'h7FF, '0);
    queue_req(OP_QUERY, '0, RIGHT_W'(1), '0);
    queue_req(OP_QUERY, INDEX_W'(5), RIGHT_W'(5), '0);
    queue_req(OP_QUERY, INDEX_W'(LEAVES - 1), '0, '0);
    queue_req(OP_QUERY, INDEX_W'(512), RIGHT_W'(513), '0);
    queue_req(OP_UNUSED, INDEX_W'(7), 11'h7FF, 32'hFFFF_FFFF);
    queue_req(OP_QUERY, '0, RIGHT_W'(LEAVES), '0);
    queue_req(OP_ADD, INDEX_W'(511), '0, -32'sd5);
    queue_req(OP_QUERY, INDEX_W'(511), RIGHT_W'(LEAVES), '0);
    queue_req(OP_QUERY, INDEX_W'(1), RIGHT_W'(LEAVES - 1), '0);
    queue_req(OP_SET, '0, '0, 32'h0);
    queue_req(OP_QUERY, '0, RIGHT_W'(LEAVES), '0);

    // Random traffic: mostly updates and queries, a few unused opcodes.
    for (int n = 0; n < RANDOM_REQS; n++) begin
      sel = $urandom_range(0, 99);
      idx = pick_index();
      case ($urandom_range(0, 9))
        0:       v = 32'h7FFF_FFFF;
        1:       v = 32'h8000_0000;
        2:       v = '0;
        3:       v = '1;
        4, 5:    v = $urandom_range(0, 200) - 100;
        default: v = $urandom;
      endcase
      case ($urandom_range(0, 9))
        6:       rend = RIGHT_W'($urandom_range(LEAVES + 1, 2047));
        7:       rend = RIGHT_W'(idx);
        8:       rend = RIGHT_W'(idx) + RIGHT_W'($urandom_range(1, 8));
        9:       rend = RIGHT_W'($urandom_range(0, idx));
        default: rend = RIGHT_W'($urandom_range(0, LEAVES));
      endcase
      if (sel < 35) queue_req(OP_SET, idx, RIGHT_W'($urandom), v);
      else if (sel < 65) queue_req(OP_ADD, idx, RIGHT_W'($urandom), v);
      else if (sel < 96) queue_req(OP_QUERY, idx, rend, $urandom);
      else queue_req(OP_UNUSED, idx, rend, v);
    end

    wait (!rst);
    while (pending_reqs.size() != 0 || expected_sums.size() != 0) @(posedge clk);
    // Let a trailing set or add finish; any stray result is still caught.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS range_sum_tree_engine");
    end else begin
      $display("FAIL range_sum_tree_engine");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/rste_pkg.sv
hw/rtl/rste_ram.sv
hw/rtl/rste_ctrl.sv
hw/rtl/rste_dp.sv
hw/rtl/range_sum_tree_engine.sv
hw/rtl/rste_checker.sv
tb/testbench.sv
